// File: design/cae_pkg.sv
// shared types, constants and saturation helpers for the segment evaluator
// no dependencies; imported by every module of the block
package cae_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W = 32;
  // magnitude width of a fixed-point product term (product < 2^63)
  localparam int TW = 2 * W - 1 - FRAC_BITS;
  // scaled radicand width and root width
  localparam int SQ_IN_W = 62;
  localparam int SQ_W = SQ_IN_W / 2;
  localparam int RAD_LIM_SH = SQ_IN_W - FRAC_BITS;
  // dividend width for time and acceleration divisions
  localparam int ND_W = W + FRAC_BITS + 1;
  // wide signed width used before saturation
  localparam int SW = 56;
  localparam int Q_DEPTH = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_START_POS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_VEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_POS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_TIME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_VEL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSED = 3'd6;

  localparam logic ACT_TIME = 1'b0;
  localparam logic ACT_POS = 1'b1;

  localparam logic signed [SW-1:0] S_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic signed [W-1:0] start_position;
    logic signed [W-1:0] start_time;
    logic signed [W-1:0] start_velocity;
    logic signed [W-1:0] end_position;
    logic signed [W-1:0] end_time;
    logic signed [W-1:0] end_velocity;
    logic                reversed_mode;
    logic signed [W-1:0] accel;
  } cfg_t;

  // classified query as queued between front and back
  typedef struct packed {
    logic                action;
    logic                hit;
    logic signed [W-1:0] q;
    logic [W-1:0]        u;
    logic                uneg;
  } entry_t;

  // sideband carried through the root pipeline
  typedef struct packed {
    logic                action;
    logic                hit;
    logic signed [W-1:0] q;
    logic [W-1:0]        u;
    logic                uneg;
    logic signed [W-1:0] pos_t;
    logic signed [W-1:0] vel_t;
    logic                big;
  } tag_t;

  // sideband carried through the divider pipeline
  typedef struct packed {
    logic                action;
    logic                hit;
    logic signed [W-1:0] q;
    logic signed [W-1:0] pos_t;
    logic signed [W-1:0] vel_t;
    logic signed [W-1:0] vel_p;
    logic                den_zero;
    logic                qneg;
  } dtag_t;

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
    if (v > S_MAX) return W_MAX;
    else if (v < S_MIN) return W_MIN;
    else return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] v);
    return sat_w(-(SW'(v)));
  endfunction

endpackage

// File: design/cae_cfg.sv
// segment registers and the serial divider that derives the acceleration
// depends on cae_pkg
module cae_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cae_pkg::W-1:0]          cfg_data,
  output cae_pkg::cfg_t                  cfg,
  output logic                           busy
);
  import cae_pkg::*;

  localparam int STEPS = ND_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic signed [W-1:0] sp, st, sv, ep, et, ev, accel;
  logic                rev;
  logic                wr, start, done;
  logic [CNT_W-1:0]    cnt;
  logic [ND_W-1:0]     nq;
  logic [W:0]          dvs, rem;
  logic                qneg, dzero;
  logic signed [W:0]   dv_diff, dur;
  logic [W:0]          dv_mag, dur_mag;
  logic [W+1:0]        trial;
  logic                ge;
  logic [W+1:0]        trial_sub;
  logic signed [SW-1:0] q_s;

  assign cfg_ready = 1'b1;
  assign wr = cfg_valid & cfg_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0; st <= '0; sv <= '0; ep <= '0; et <= '0; ev <= '0; rev <= 1'b0;
    end else if (wr) begin
      unique case (cfg_index)
        REG_START_POS:  sp <= cfg_data;
        REG_START_TIME: st <= cfg_data;
        REG_START_VEL:  sv <= cfg_data;
        REG_END_POS:    ep <= cfg_data;
        REG_END_TIME:   et <= cfg_data;
        REG_END_VEL:    ev <= cfg_data;
        REG_REVERSED:   rev <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // divider operands, magnitudes and signs
  assign dv_diff = {ev[W-1], ev} - {sv[W-1], sv};
  assign dur = {et[W-1], et} - {st[W-1], st};
  assign dv_mag = dv_diff[W] ? -dv_diff : dv_diff;
  assign dur_mag = dur[W] ? -dur : dur;

  // one quotient bit per cycle
  assign trial = {rem, nq[ND_W-1]};
  assign ge = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};
  assign q_s = signed'(SW'(nq));

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
      accel <= '0;
    end else begin
      start <= wr;
      done <= (cnt == CNT_W'(1));
      if (start) begin
        cnt <= CNT_W'(STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
      if (done) begin
        accel <= dzero ? '0 : sat_w(qneg ? -q_s : q_s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq <= {dv_mag, {FRAC_BITS{1'b0}}};
      dvs <= dur_mag;
      rem <= '0;
      qneg <= dv_diff[W] ^ dur[W];
      dzero <= (dur == '0);
    end else if (cnt != '0) begin
      rem <= ge ? trial_sub[W:0] : trial[W:0];
      nq <= {nq[ND_W-2:0], ge};
    end
  end

  assign busy = start | done | (cnt != '0);

  assign cfg.start_position = sp;
  assign cfg.start_time = st;
  assign cfg.start_velocity = sv;
  assign cfg.end_position = ep;
  assign cfg.end_time = et;
  assign cfg.end_velocity = ev;
  assign cfg.reversed_mode = rev;
  assign cfg.accel = accel;

  a_write_busy: assert property (@(posedge clk) disable iff (rst) wr |=> busy)
    else $error("acceleration update not started after register write");

endmodule

// File: design/cae_front.sv
// query intake: range check, offset magnitude, and a short queue to the back end
// depends on cae_pkg
module cae_front (
  input  logic                  clk,
  input  logic                  rst,
  input  cae_pkg::cfg_t         cfg,
  input  logic                  busy,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [cae_pkg::W-1:0] s_axis_tdata,
  input  logic [0:0]            s_axis_tuser,
  input  logic                  pop,
  output logic                  head_v,
  output cae_pkg::entry_t       head
);
  import cae_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  entry_t              mem [Q_DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                push;
  logic signed [W-1:0] q;
  logic signed [W:0]   dx;
  logic [W:0]          dx_mag;
  logic [W-1:0]        dt;
  logic                hit_t, hit_p;
  entry_t              ent;

  assign q = s_axis_tdata;

  // classify the query against the segment
  always_comb begin
    hit_t = (q >= cfg.start_time) && (q <= cfg.end_time);
    if (cfg.end_position < cfg.start_position) begin
      hit_p = (q >= cfg.end_position) && (q <= cfg.start_position);
    end else begin
      hit_p = (q >= cfg.start_position) && (q <= cfg.end_position);
    end
    dt = q - cfg.start_time;
    dx = {q[W-1], q} - {cfg.start_position[W-1], cfg.start_position};
    dx_mag = dx[W] ? -dx : dx;
    ent.action = s_axis_tuser[0];
    ent.q = q;
    if (s_axis_tuser[0] == ACT_POS) begin
      ent.hit = hit_p;
      ent.u = dx_mag[W-1:0];
      ent.uneg = dx[W];
    end else begin
      ent.hit = hit_t;
      ent.u = dt;
      ent.uneg = 1'b0;
    end
  end

  assign s_axis_tready = (count != CNT_W'(Q_DEPTH)) & ~busy;
  assign push = s_axis_tvalid & s_axis_tready;
  assign head_v = (count != '0);
  assign head = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= ent;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
      (count == CNT_W'(Q_DEPTH)) |-> !push)
    else $error("queue written while full");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a transfer");

endmodule

// File: design/cae_sqrt.sv
// pipelined integer square root, one result bit per stage, floor of the root
// depends on cae_pkg
module cae_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [cae_pkg::SQ_IN_W-1:0] in_x,
  input  cae_pkg::tag_t               in_tag,
  output logic                        out_v,
  output logic [cae_pkg::SQ_W-1:0]    out_root,
  output cae_pkg::tag_t               out_tag
);
  import cae_pkg::*;

  localparam int RW = SQ_W + 3;

  logic               v     [SQ_W];
  logic [SQ_IN_W-1:0] x     [SQ_W];
  logic [RW-1:0]      rem   [SQ_W];
  logic [SQ_W-1:0]    root  [SQ_W];
  tag_t               tag   [SQ_W];

  logic [SQ_IN_W-1:0] src_x    [SQ_W];
  logic [RW-1:0]      src_rem  [SQ_W];
  logic [SQ_W-1:0]    src_root [SQ_W];
  logic [RW-1:0]      sh       [SQ_W];
  logic [RW-1:0]      trial    [SQ_W];
  logic               ge       [SQ_W];

  // one root bit per stage from the next two radicand bits
  always_comb begin
    src_x[0] = in_x;
    src_rem[0] = '0;
    src_root[0] = '0;
    for (int k = 1; k < SQ_W; k++) begin
      src_x[k] = x[k-1];
      src_rem[k] = rem[k-1];
      src_root[k] = root[k-1];
    end
    for (int k = 0; k < SQ_W; k++) begin
      sh[k] = {src_rem[k][RW-3:0], src_x[k][SQ_IN_W-1 -: 2]};
      trial[k] = RW'({src_root[k], 2'b01});
      ge[k] = sh[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQ_W; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[0] <= in_v;
      for (int k = 1; k < SQ_W; k++) v[k] <= v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= in_tag;
      for (int k = 1; k < SQ_W; k++) tag[k] <= tag[k-1];
      for (int k = 0; k < SQ_W; k++) begin
        x[k] <= {src_x[k][SQ_IN_W-3:0], 2'b00};
        rem[k] <= ge[k] ? (sh[k] - trial[k]) : sh[k];
        root[k] <= {src_root[k][SQ_W-2:0], ge[k]};
      end
    end
  end

  assign out_v = v[SQ_W-1];
  assign out_root = root[SQ_W-1];
  assign out_tag = tag[SQ_W-1];

endmodule

// File: design/cae_div.sv
// pipelined restoring divider on magnitudes, one quotient bit per stage
// depends on cae_pkg
module cae_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_v,
  input  logic [cae_pkg::ND_W-1:0] in_n,
  input  logic [cae_pkg::W-1:0]    in_d,
  input  cae_pkg::dtag_t           in_tag,
  output logic                     out_v,
  output logic [cae_pkg::ND_W-1:0] out_quot,
  output cae_pkg::dtag_t           out_tag
);
  import cae_pkg::*;

  logic            v   [ND_W];
  logic [ND_W-1:0] nq  [ND_W];
  logic [W-1:0]    rem [ND_W];
  logic [W-1:0]    d   [ND_W];
  dtag_t           tag [ND_W];

  logic [ND_W-1:0] src_nq  [ND_W];
  logic [W-1:0]    src_rem [ND_W];
  logic [W-1:0]    src_d   [ND_W];
  logic [W:0]      sh      [ND_W];
  logic [W:0]      diff    [ND_W];
  logic            ge      [ND_W];

  // shift in the next dividend bit and try the divisor
  always_comb begin
    src_nq[0] = in_n;
    src_rem[0] = '0;
    src_d[0] = in_d;
    for (int k = 1; k < ND_W; k++) begin
      src_nq[k] = nq[k-1];
      src_rem[k] = rem[k-1];
      src_d[k] = d[k-1];
    end
    for (int k = 0; k < ND_W; k++) begin
      sh[k] = {src_rem[k], src_nq[k][ND_W-1]};
      diff[k] = sh[k] - {1'b0, src_d[k]};
      ge[k] = sh[k] >= {1'b0, src_d[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ND_W; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[0] <= in_v;
      for (int k = 1; k < ND_W; k++) v[k] <= v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= in_tag;
      for (int k = 1; k < ND_W; k++) tag[k] <= tag[k-1];
      for (int k = 0; k < ND_W; k++) begin
        nq[k] <= {src_nq[k][ND_W-2:0], ge[k]};
        rem[k] <= ge[k] ? diff[k][W-1:0] : sh[k][W-1:0];
        d[k] <= src_d[k];
      end
    end
  end

  assign out_v = v[ND_W-1];
  assign out_quot = nq[ND_W-1];
  assign out_tag = tag[ND_W-1];

endmodule

// File: design/cae_back.sv
// arithmetic back end: products, root and divider pipelines, output register
// depends on cae_pkg, cae_sqrt, cae_div
module cae_back (
  input  logic                      clk,
  input  logic                      rst,
  input  cae_pkg::cfg_t             cfg,
  input  logic                      head_v,
  input  cae_pkg::entry_t           head,
  output logic                      pop,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [4*cae_pkg::W-1:0]   m_axis_tdata,
  output logic [1:0]                m_axis_tuser
);
  import cae_pkg::*;

  localparam int LO_W = (TW + 1) / 2;
  localparam int HI_W = TW - LO_W;
  localparam int FULL_W = TW + W;
  localparam int T2W = FULL_W - FRAC_BITS - 1;
  localparam int RAD_W = TW + 3;

  logic en;

  // stage 1: queued item
  logic   s1_v;
  entry_t s1;
  logic [W-1:0]   acc_mag, sv_mag;
  logic [2*W-1:0] macc_c, msv_c;

  // stage 2: raw products
  logic           s2_v;
  entry_t         s2;
  logic [2*W-1:0] s2_macc, s2_msv;

  // stage 3: scaled magnitudes
  logic          s3_v;
  entry_t        s3;
  logic [TW-1:0] s3_mmag, s3_svs;
  logic          s3_mneg;
  logic [LO_W+W-1:0]    p1_c;
  logic [HI_W+W-1:0]    p2_c;
  logic signed [TW:0]   ms_c, t3_c;
  logic signed [RAD_W-1:0] rad_c;

  // stage 4: split products, signed terms, radicand
  logic                    s4_v;
  entry_t                  s4;
  logic [LO_W+W-1:0]       s4_p1;
  logic [HI_W+W-1:0]       s4_p2;
  logic signed [TW:0]      s4_ms, s4_t3;
  logic signed [RAD_W-1:0] s4_rad;
  logic                    s4_mneg;
  logic [FULL_W-1:0]       full_c;
  logic [T2W-1:0]          t2_full_c;
  logic [TW-1:0]           t2mag_c;
  logic                    big_c;
  logic [SQ_IN_W-1:0]      sqin_c;

  // stage 5: time-query results and root operand
  logic                s5_v;
  entry_t              s5;
  logic [TW-1:0]       s5_t2mag;
  logic                s5_mneg, s5_big;
  logic signed [TW:0]  s5_t3;
  logic signed [W-1:0] s5_vel_t;
  logic [SQ_IN_W-1:0]  s5_sqin;
  logic signed [TW:0]  t2s_c;
  tag_t                sq_in_tag;

  // root and divider
  logic                sq_v;
  logic [SQ_W-1:0]     sq_root;
  tag_t                sq_tag;
  logic signed [W-1:0] vel_p_c;
  logic signed [W:0]   den_c;
  logic [W:0]          den_mag_c;
  dtag_t               dv_in_tag;
  logic                dv_v;
  logic [ND_W-1:0]     dv_quot;
  dtag_t               dv_tag;

  // final selection
  logic signed [SW-1:0] tq_c;
  logic signed [W-1:0]  pos_o, tim_o, vel_o, acc_o;
  logic                 seg_valid;

  assign en = ~m_axis_tvalid | m_axis_tready;
  assign pop = en & head_v;

  // stage 1 -> 2 multiplies
  always_comb begin
    acc_mag = cfg.accel[W-1] ? W'(-cfg.accel) : W'(cfg.accel);
    sv_mag = cfg.start_velocity[W-1] ? W'(-cfg.start_velocity) : W'(cfg.start_velocity);
    macc_c = acc_mag * s1.u;
    msv_c = sv_mag * ((s1.action == ACT_POS) ? sv_mag : s1.u);
  end

  // stage 3 -> 4 split multiply and signed terms
  always_comb begin
    p1_c = s3_mmag[LO_W-1:0] * s3.u;
    p2_c = s3_mmag[TW-1:LO_W] * s3.u;
    ms_c = s3_mneg ? -$signed({1'b0, s3_mmag}) : $signed({1'b0, s3_mmag});
    t3_c = cfg.start_velocity[W-1] ? -$signed({1'b0, s3_svs}) : $signed({1'b0, s3_svs});
    rad_c = $signed({ms_c[TW], ms_c, 1'b0}) + $signed({3'b000, s3_svs});
  end

  // stage 4 -> 5 term sums and radicand clamp
  always_comb begin
    full_c = {s4_p2, {LO_W{1'b0}}} + FULL_W'(s4_p1);
    t2_full_c = full_c[FULL_W-1:FRAC_BITS+1];
    t2mag_c = (|t2_full_c[T2W-1:TW]) ? {TW{1'b1}} : t2_full_c[TW-1:0];
    big_c = ~s4_rad[RAD_W-1] & (|s4_rad[RAD_W-2:RAD_LIM_SH]);
    sqin_c = (s4_rad[RAD_W-1] || big_c) ? '0
           : {s4_rad[RAD_LIM_SH-1:0], {FRAC_BITS{1'b0}}};
  end

  // stage 5 -> root: position of a time query
  always_comb begin
    t2s_c = s5_mneg ? -$signed({1'b0, s5_t2mag}) : $signed({1'b0, s5_t2mag});
    sq_in_tag.action = s5.action;
    sq_in_tag.hit = s5.hit;
    sq_in_tag.q = s5.q;
    sq_in_tag.u = s5.u;
    sq_in_tag.uneg = s5.uneg;
    sq_in_tag.pos_t = sat_w(SW'(cfg.start_position) + SW'(t2s_c) + SW'(s5_t3));
    sq_in_tag.vel_t = s5_vel_t;
    sq_in_tag.big = s5_big;
  end

  // front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; s4_v <= 1'b0; s5_v <= 1'b0;
    end else if (en) begin
      s1_v <= head_v; s2_v <= s1_v; s3_v <= s2_v; s4_v <= s3_v; s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= head;
      s2 <= s1;
      s2_macc <= macc_c;
      s2_msv <= msv_c;
      s3 <= s2;
      s3_mmag <= s2_macc[FRAC_BITS +: TW];
      s3_svs <= s2_msv[FRAC_BITS +: TW];
      s3_mneg <= cfg.accel[W-1] ^ s2.uneg;
      s4 <= s3;
      s4_p1 <= p1_c;
      s4_p2 <= p2_c;
      s4_ms <= ms_c;
      s4_t3 <= t3_c;
      s4_rad <= rad_c;
      s4_mneg <= s3_mneg;
      s5 <= s4;
      s5_t2mag <= t2mag_c;
      s5_mneg <= s4_mneg;
      s5_t3 <= s4_t3;
      s5_vel_t <= sat_w(SW'(cfg.start_velocity) + SW'(s4_ms));
      s5_big <= big_c;
      s5_sqin <= sqin_c;
    end
  end

  cae_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (s5_v),
    .in_x     (s5_sqin),
    .in_tag   (sq_in_tag),
    .out_v    (sq_v),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  // velocity from the root, divisor for the time of a position query
  always_comb begin
    vel_p_c = sq_tag.big ? W_MAX : $signed({{(W-SQ_W){1'b0}}, sq_root});
    den_c = {cfg.start_velocity[W-1], cfg.start_velocity} + {1'b0, vel_p_c};
    den_mag_c = den_c[W] ? -den_c : den_c;
    dv_in_tag.action = sq_tag.action;
    dv_in_tag.hit = sq_tag.hit;
    dv_in_tag.q = sq_tag.q;
    dv_in_tag.pos_t = sq_tag.pos_t;
    dv_in_tag.vel_t = sq_tag.vel_t;
    dv_in_tag.vel_p = vel_p_c;
    dv_in_tag.den_zero = (den_c == '0);
    dv_in_tag.qneg = sq_tag.uneg ^ den_c[W];
  end

  cae_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (sq_v),
    .in_n     ({sq_tag.u, {(FRAC_BITS+1){1'b0}}}),
    .in_d     (den_mag_c[W-1:0]),
    .in_tag   (dv_in_tag),
    .out_v    (dv_v),
    .out_quot (dv_quot),
    .out_tag  (dv_tag)
  );

  // result selection, reversal and miss handling
  always_comb begin
    tq_c = dv_tag.qneg ? -$signed(SW'(dv_quot)) : $signed(SW'(dv_quot));
    seg_valid = (cfg.end_time >= cfg.start_time);
    acc_o = cfg.reversed_mode ? neg_sat(cfg.accel) : cfg.accel;
    if (dv_tag.action == ACT_TIME) begin
      tim_o = dv_tag.q;
      pos_o = cfg.reversed_mode
            ? sat_w(SW'(cfg.end_position) - SW'(dv_tag.pos_t)) : dv_tag.pos_t;
      vel_o = cfg.reversed_mode ? neg_sat(dv_tag.vel_t) : dv_tag.vel_t;
    end else begin
      pos_o = dv_tag.q;
      tim_o = dv_tag.den_zero ? cfg.start_time : sat_w(tq_c + SW'(cfg.start_time));
      vel_o = cfg.reversed_mode ? neg_sat(dv_tag.vel_p) : dv_tag.vel_p;
    end
    if (!dv_tag.hit) begin
      pos_o = '0;
      tim_o = '0;
      vel_o = '0;
      acc_o = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {acc_o, vel_o, tim_o, pos_o};
      m_axis_tuser <= {seg_valid, dv_tag.hit};
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
      (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("miss result carries nonzero data");

endmodule

// File: design/const_accel_segment_eval.sv
// Constant-acceleration segment evaluator, top level.
// Throughput: one query per cycle, set by the bit-per-stage root and divider pipes,
// while the output is ready and no acceleration update is running. A register write
// holds off input while the serial divider recomputes the acceleration. Synchronous
// active-high reset clears control and configuration state, not datapath registers.
module const_accel_segment_eval (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [cae_pkg::W-1:0]          s_axis_tdata,  // query_value
  input  logic [0:0]                     s_axis_tuser,  // action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_position, out_time, out_velocity, out_acceleration
  output logic [4*cae_pkg::W-1:0]        m_axis_tdata,
  output logic [1:0]                     m_axis_tuser,  // hit, segment_valid
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cae_pkg::W-1:0]          cfg_data
);
  import cae_pkg::*;

  cfg_t   cfg;
  logic   busy;
  logic   head_v, pop;
  entry_t head;

  cae_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .busy      (busy)
  );

  cae_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .busy          (busy),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop           (pop),
    .head_v        (head_v),
    .head          (head)
  );

  cae_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head_v        (head_v),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
